// ===== src/lps_pkg.sv =====
`timescale 1ns / 1ps

package lps_pkg;

    localparam int LED_W      = 5;
    localparam int IDX_W      = 4;
    localparam int DUR_W      = 16;
    localparam int TICKS_W    = 13;
    localparam int NRES_W     = 5;

    localparam logic [TICKS_W-1:0] TICK_MAX    = 13'd8191;
    localparam logic [NRES_W-1:0]  MAX_RESULTS = 5'd16;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_START  = 3'd1,
        CMD_TICK   = 3'd2,
        CMD_PAUSE  = 3'd3,
        CMD_RESUME = 3'd4,
        CMD_STOP   = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [LED_W-1:0]   led;
        logic [TICKS_W-1:0] ticks;
    } t_entry;

endpackage

// ===== src/lps_ram.sv =====
`timescale 1ns / 1ps

module lps_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/lps_tick_div.sv =====
`timescale 1ns / 1ps

module lps_tick_div
    import lps_pkg::*;
#(
    parameter int TICK_MS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DUR_W-1:0]   i_dividend,
    output logic               o_done,
    output logic [TICKS_W-1:0] o_ticks
);

    // Division by the constant TICK_MS as a multiply by a rounded-up reciprocal.
    // With SHIFT = DUR_W + ceil(log2(TICK_MS)) the quotient is exact for every
    // DUR_W-bit dividend.
    localparam int SHIFT  = DUR_W + $clog2(TICK_MS);
    localparam int RCP_W  = DUR_W + 2;
    localparam int PROD_W = DUR_W + RCP_W;
    localparam logic [63:0] RCP_VAL =
        ((64'd1 << SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_VAL);

    logic              r_done;
    logic [PROD_W-1:0] r_prod;
    logic [DUR_W-1:0]  quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_prod <= '0;
        end else begin
            r_done <= i_start;
            if (i_start) begin
                r_prod <= PROD_W'(i_dividend) * PROD_W'(RECIP);
            end
        end
    end

    assign quot    = DUR_W'(r_prod >> SHIFT);
    assign o_done  = r_done;
    assign o_ticks = (quot > DUR_W'(TICK_MAX)) ? TICK_MAX : quot[TICKS_W-1:0];

endmodule

// ===== src/led_pattern_sequencer.sv =====
`timescale 1ns / 1ps

// Plays a table of LED steps. Items arrive on the input channel (valid/ready) and
// carry a command: load an entry, start, tick, pause, resume or stop. Each item
// gives zero or more results on the output channel (valid/ready), the final one
// flagged by o_last. The repeat count is written over the APB port at offset 0.
// One item is worked on at a time; o_in_ready is high whenever the sequencer is
// idle, even while a result still waits in the output register.
// After a load is accepted the input stays busy in S_DIV: the tick count comes
// from a constant reciprocal multiply, registered in the divider, and is written
// to the table in S_DIV. A start scans the table through the single memory read
// port, one entry per cycle, and then forms its first result in S_SHOW. Every
// further entry shown in the same item passes through S_ADV, which steps the
// position and reads the memory, and then S_SHOW, which forms the result. Tick
// and pause without a walk stay idle; stop forms its finished result in S_FIN.
// After reset the table reads as empty, the repeat count is 0 and nothing runs.
// When the receiver stalls, the sequencer holds in place until the output
// register frees up; no result is lost.

module led_pattern_sequencer
    import lps_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_LIMIT    = 32,
    parameter int TICK_MS     = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_command,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic [LED_W-1:0]   i_led_id,
    input  logic [DUR_W-1:0]   i_duration_ms,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [LED_W-1:0]   o_shown_led,
    output logic [IDX_W-1:0]   o_shown_index,
    output logic [DUR_W-1:0]   o_shown_duration,
    output logic               o_finished,
    output logic               o_last,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int RLW = $clog2(TABLE_DEPTH + 1);
    localparam int MW  = $clog2(TICK_MS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [MW-1:0] TICK_MULT = MW'(TICK_MS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_SHOW,
        S_ADV,
        S_FIN
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_pos, n_pos;
    logic [RLW-1:0]     r_rl, n_rl;
    logic [TICKS_W-1:0] r_hold, n_hold;
    logic [7:0]         r_passes, n_passes;
    logic               r_running, n_running;
    logic               r_paused, n_paused;
    logic [7:0]         r_repeat;
    logic [AW-1:0]      r_scan, n_scan;
    logic [NRES_W-1:0]  r_nres, n_nres;
    logic [RLW-1:0]     r_shows, n_shows;
    logic [AW-1:0]      r_ld_addr, n_ld_addr;
    logic [LED_W-1:0]   r_ld_led, n_ld_led;
    logic [TABLE_DEPTH-1:0] r_vld, n_vld;

    logic               r_out_valid, n_out_valid;
    logic [LED_W-1:0]   r_o_led, n_o_led;
    logic [IDX_W-1:0]   r_o_idx, n_o_idx;
    logic [DUR_W-1:0]   r_o_dur, n_o_dur;
    logic               r_o_fin, n_o_fin;
    logic               r_o_last, n_o_last;

    logic               in_acc;
    logic               out_free;
    logic               div_start;
    logic               div_done;
    logic [TICKS_W-1:0] div_ticks;
    logic [AW-1:0]      rd_addr;
    logic [$bits(t_entry)-1:0] rd_raw;
    t_entry             rd_ent;
    t_entry             wr_ent;
    logic               rd_vld;
    logic [LED_W-1:0]   ent_led;
    logic [TICKS_W-1:0] ent_ticks;
    logic [TICKS_W+MW-1:0] dur_prod;
    logic               id_ok;
    logic [RLW-1:0]     rl_final;
    logic [NRES_W-1:0]  nres_inc;
    logic [RLW-1:0]     shows_inc;
    logic               walk_more;
    logic [RLW-1:0]     pos_inc;
    logic               wrap;
    logic [TICKS_W-1:0] hold_dec;
    logic               cfg_wr;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_repeat};

    assign wr_ent.led   = r_ld_led;
    assign wr_ent.ticks = div_ticks;

    lps_tick_div #(
        .TICK_MS(TICK_MS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_duration_ms),
        .o_done     (div_done),
        .o_ticks    (div_ticks)
    );

    lps_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (div_done),
        .i_waddr (r_ld_addr),
        .i_wdata (wr_ent),
        .i_raddr (rd_addr),
        .o_rdata (rd_raw)
    );

    assign rd_ent    = t_entry'(rd_raw);
    assign rd_vld    = (r_state == S_SCAN) ? r_vld[r_scan] : r_vld[r_pos];
    assign ent_led   = rd_vld ? rd_ent.led : '0;
    assign ent_ticks = rd_vld ? rd_ent.ticks : '0;
    assign dur_prod  = ent_ticks * TICK_MULT;

    assign id_ok     = (ent_led != '0) && (32'(ent_led) < ID_LIMIT);
    assign rl_final  = id_ok ? (RLW'(r_scan) + RLW'(1)) : r_rl;

    assign nres_inc  = r_nres + NRES_W'(1);
    assign shows_inc = r_shows + RLW'(1);
    assign walk_more = (ent_ticks == '0) && (shows_inc < r_rl) && (nres_inc < MAX_RESULTS);

    assign pos_inc   = RLW'(r_pos) + RLW'(1);
    assign wrap      = (pos_inc == r_rl);
    assign hold_dec  = (r_hold != '0) ? (r_hold - TICKS_W'(1)) : r_hold;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_rl        = r_rl;
        n_hold      = r_hold;
        n_passes    = r_passes;
        n_running   = r_running;
        n_paused    = r_paused;
        n_scan      = r_scan;
        n_nres      = r_nres;
        n_shows     = r_shows;
        n_ld_addr   = r_ld_addr;
        n_ld_led    = r_ld_led;
        n_vld       = r_vld;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_led     = r_o_led;
        n_o_idx     = r_o_idx;
        n_o_dur     = r_o_dur;
        n_o_fin     = r_o_fin;
        n_o_last    = r_o_last;
        div_start   = 1'b0;
        rd_addr     = r_pos;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_command)
                        CMD_LOAD: begin
                            if (32'(i_entry_index) < TABLE_DEPTH) begin
                                div_start = 1'b1;
                                n_ld_addr = AW'(i_entry_index);
                                n_ld_led  = i_led_id;
                                n_state   = S_DIV;
                            end
                        end
                        CMD_START: begin
                            rd_addr  = '0;
                            n_scan   = '0;
                            n_rl     = '0;
                            n_pos    = '0;
                            n_paused = 1'b0;
                            n_passes = r_repeat;
                            n_nres   = '0;
                            n_shows  = '0;
                            n_state  = S_SCAN;
                        end
                        CMD_TICK: begin
                            if (r_running && !r_paused) begin
                                n_hold = hold_dec;
                                if (hold_dec == '0) begin
                                    n_nres  = '0;
                                    n_shows = '0;
                                    n_state = S_ADV;
                                end
                            end
                        end
                        CMD_PAUSE: begin
                            if (r_running) begin
                                n_paused = 1'b1;
                            end
                        end
                        CMD_RESUME: begin
                            if (r_running && r_paused) begin
                                n_paused = 1'b0;
                                n_nres   = '0;
                                n_shows  = '0;
                                n_state  = S_SHOW;
                            end
                        end
                        CMD_STOP: begin
                            n_running = 1'b0;
                            n_paused  = 1'b0;
                            n_state   = S_FIN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_vld[r_ld_addr] = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SCAN: begin
                if (id_ok && (r_scan != LAST_ADDR)) begin
                    n_rl    = rl_final;
                    n_scan  = r_scan + AW'(1);
                    rd_addr = r_scan + AW'(1);
                end else begin
                    n_rl    = rl_final;
                    rd_addr = '0;
                    if (rl_final == '0) begin
                        n_running = 1'b0;
                        n_paused  = 1'b0;
                        n_state   = S_FIN;
                    end else begin
                        n_running = 1'b1;
                        n_state   = S_SHOW;
                    end
                end
            end
            S_SHOW: begin
                if (out_free) begin
                    n_hold      = ent_ticks;
                    n_out_valid = 1'b1;
                    n_o_led     = ent_led;
                    n_o_idx     = IDX_W'(r_pos);
                    n_o_dur     = DUR_W'(dur_prod);
                    n_o_fin     = 1'b0;
                    n_o_last    = !walk_more;
                    n_nres      = nres_inc;
                    n_shows     = shows_inc;
                    n_state     = walk_more ? S_ADV : S_IDLE;
                end
            end
            S_ADV: begin
                n_pos   = wrap ? '0 : AW'(pos_inc);
                rd_addr = wrap ? '0 : AW'(pos_inc);
                n_state = S_SHOW;
                if (wrap && (r_passes != '0)) begin
                    n_passes = r_passes - 8'd1;
                    if (r_passes == 8'd1) begin
                        n_running = 1'b0;
                        n_paused  = 1'b0;
                        n_state   = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_led     = '0;
                    n_o_idx     = '0;
                    n_o_dur     = '0;
                    n_o_fin     = 1'b1;
                    n_o_last    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_rl        <= '0;
            r_hold      <= '0;
            r_passes    <= '0;
            r_running   <= 1'b0;
            r_paused    <= 1'b0;
            r_repeat    <= '0;
            r_scan      <= '0;
            r_nres      <= '0;
            r_shows     <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_rl        <= n_rl;
            r_hold      <= n_hold;
            r_passes    <= n_passes;
            r_running   <= n_running;
            r_paused    <= n_paused;
            r_scan      <= n_scan;
            r_nres      <= n_nres;
            r_shows     <= n_shows;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_repeat <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ld_addr <= n_ld_addr;
        r_ld_led  <= n_ld_led;
        r_o_led   <= n_o_led;
        r_o_idx   <= n_o_idx;
        r_o_dur   <= n_o_dur;
        r_o_fin   <= n_o_fin;
        r_o_last  <= n_o_last;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_shown_led      = r_o_led;
    assign o_shown_index    = r_o_idx;
    assign o_shown_duration = r_o_dur;
    assign o_finished       = r_o_fin;
    assign o_last           = r_o_last;

endmodule

// ===== bench/led_pattern_sequencer_tb.sv =====
`timescale 1ns / 1ps

module led_pattern_sequencer_tb
    import lps_pkg::*;
();

    localparam int TABLE_DEPTH    = 16;
    localparam int ID_LIMIT       = 32;
    localparam int TICK_MS        = 10;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 15;

    localparam logic [2:0] REPEAT_COUNT_ADDR = 3'd0;
    localparam logic [2:0] CMD_RSVD6         = 3'd6;
    localparam logic [2:0] CMD_RSVD7         = 3'd7;

    typedef struct packed {
        logic [LED_W-1:0] led;
        logic [IDX_W-1:0] idx;
        logic [DUR_W-1:0] dur;
        logic             fin;
        logic             is_last;
    } t_show;

    class led_show_scoreboard;
        logic [LED_W-1:0]   led_tab [TABLE_DEPTH];
        logic [TICKS_W-1:0] ticks_tab [TABLE_DEPTH];
        int unsigned pos, run_len, hold, passes;
        bit          running, paused;
        logic [7:0]  repeat_cfg;
        t_show       step_shows [$];
        t_show       pending_shows [$];
        int          errors, n_items, n_results, n_finished;

        function new();
            foreach (led_tab[i]) begin
                led_tab[i]   = '0;
                ticks_tab[i] = '0;
            end
            pos = 0; run_len = 0; hold = 0; passes = 0;
            running = 0; paused = 0; repeat_cfg = '0;
            errors = 0; n_items = 0; n_results = 0; n_finished = 0;
        endfunction

        function void show_entry(bit done);
            t_show s;
            int unsigned ms;
            s = '0;
            if (done) begin
                s.fin = 1'b1;
            end else begin
                ms    = ticks_tab[pos] * TICK_MS;
                s.led = led_tab[pos];
                s.idx = pos[IDX_W-1:0];
                s.dur = ms[DUR_W-1:0];
            end
            step_shows.push_back(s);
        endfunction

        function bit advance();
            if (run_len == 0) begin
                running = 0; paused = 0;
                return 1'b1;
            end
            pos = (pos + 1) % run_len;
            if (pos == 0 && passes != 0) begin
                passes--;
                if (passes == 0) begin
                    running = 0; paused = 0;
                    return 1'b1;
                end
            end
            hold = ticks_tab[pos];
            return 1'b0;
        endfunction

        function void walk(int unsigned shows);
            while (running && hold == 0 && shows < run_len
                   && step_shows.size() < int'(MAX_RESULTS)) begin
                if (advance()) begin
                    show_entry(1'b1);
                    return;
                end
                show_entry(1'b0);
                shows++;
            end
        endfunction

        function void note_command(logic [2:0] cmd, logic [IDX_W-1:0] idx,
                                   logic [LED_W-1:0] led, logic [DUR_W-1:0] dur);
            int unsigned t;
            step_shows.delete();
            n_items++;
            case (cmd)
                CMD_LOAD: begin
                    if (int'(idx) < TABLE_DEPTH) begin
                        t = dur / TICK_MS;
                        if (t > TICK_MAX) t = TICK_MAX;
                        led_tab[idx]   = led;
                        ticks_tab[idx] = t[TICKS_W-1:0];
                    end
                end
                CMD_START: begin
                    run_len = 0;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (led_tab[i] > 0 && int'(led_tab[i]) < ID_LIMIT) run_len = i + 1;
                        else break;
                    end
                    pos = 0;
                    paused = 0;
                    passes = repeat_cfg;
                    if (run_len == 0) begin
                        running = 0;
                        show_entry(1'b1);
                    end else begin
                        running = 1;
                        hold = ticks_tab[0];
                        show_entry(1'b0);
                        walk(1);
                    end
                end
                CMD_TICK: begin
                    if (running && !paused) begin
                        if (hold > 0) hold--;
                        if (hold == 0) walk(0);
                    end
                end
                CMD_PAUSE: begin
                    if (running) paused = 1;
                end
                CMD_RESUME: begin
                    if (running && paused) begin
                        paused = 0;
                        hold = ticks_tab[pos];
                        show_entry(1'b0);
                        walk(1);
                    end
                end
                CMD_STOP: begin
                    running = 0;
                    paused = 0;
                    show_entry(1'b1);
                end
                default: ;
            endcase
            if (step_shows.size() > 0) step_shows[step_shows.size()-1].is_last = 1'b1;
            foreach (step_shows[i]) pending_shows.push_back(step_shows[i]);
        endfunction

        function void check_show(t_show got);
            t_show want;
            n_results++;
            if (got.fin === 1'b1) n_finished++;
            if (pending_shows.size() == 0) begin
                $error("Result with no item behind it: led %0d index %0d duration %0d fin %0b",
                       got.led, got.idx, got.dur, got.fin);
                errors++;
                return;
            end
            want = pending_shows.pop_front();
            if (got.led !== want.led) begin
                $error("shown_led: expected %0d, got %0d", want.led, got.led);
                errors++;
            end
            if (got.idx !== want.idx) begin
                $error("shown_index: expected %0d, got %0d", want.idx, got.idx);
                errors++;
            end
            if (got.dur !== want.dur) begin
                $error("shown_duration: expected %0d, got %0d", want.dur, got.dur);
                errors++;
            end
            if (got.fin !== want.fin) begin
                $error("finished: expected %0b, got %0b", want.fin, got.fin);
                errors++;
            end
            if (got.is_last !== want.is_last) begin
                $error("last: expected %0b, got %0b", want.is_last, got.is_last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_command;
    logic [IDX_W-1:0]   i_entry_index;
    logic [LED_W-1:0]   i_led_id;
    logic [DUR_W-1:0]   i_duration_ms;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [LED_W-1:0]   o_shown_led;
    logic [IDX_W-1:0]   o_shown_index;
    logic [DUR_W-1:0]   o_shown_duration;
    logic               o_finished;
    logic               o_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    led_show_scoreboard sb;
    bit                 quiet_mode;
    bit                 hold_req;
    int                 stuck_cycles;

    led_pattern_sequencer #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_LIMIT    (ID_LIMIT),
        .TICK_MS     (TICK_MS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_entry_index    (i_entry_index),
        .i_led_id         (i_led_id),
        .i_duration_ms    (i_duration_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_shown_led      (o_shown_led),
        .o_shown_index    (o_shown_index),
        .o_shown_duration (o_shown_duration),
        .o_finished       (o_finished),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_command(input logic [2:0] cmd, input logic [IDX_W-1:0] idx,
                                input logic [LED_W-1:0] led, input logic [DUR_W-1:0] dur);
        int gap;
        gap = quiet_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_command     = cmd;
        i_entry_index = idx;
        i_led_id      = led;
        i_duration_ms = dur;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_command(cmd, idx, led, dur);
        @(negedge i_clk);
    endtask

    task automatic push_op(input logic [2:0] cmd);
        push_command(cmd, IDX_W'($urandom), LED_W'($urandom), DUR_W'($urandom));
    endtask

    task automatic settle_idle();
        i_in_valid = 1'b0;
        while (sb.pending_shows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_repeat_count(input logic [7:0] value);
        logic [31:0] rd;
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = REPEAT_COUNT_ADDR; pwdata = {24'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        sb.repeat_cfg = value;
        pwrite = 1'b0; penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
        if (rd[7:0] !== value) begin
            $error("repeat_count: expected %0d, got %0d", value, rd[7:0]);
            sb.errors++;
        end
    endtask

    task automatic play_phase(input int n_cmds, input bit with_hold);
        int  sent, len, ops, r;
        bit  zero_run;
        logic [DUR_W-1:0] dur;
        sent = 0;
        while (sent < n_cmds) begin
            zero_run = ($urandom_range(5) == 0);
            len = (zero_run || $urandom_range(9) == 0) ? TABLE_DEPTH : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                if (zero_run) dur = DUR_W'($urandom_range(0, TICK_MS - 1));
                else if ($urandom_range(24) == 0) dur = DUR_W'($urandom);
                else dur = DUR_W'($urandom_range(0, 45));
                push_command(CMD_LOAD, IDX_W'(i), LED_W'($urandom_range(1, 31)), dur);
            end
            if (len < TABLE_DEPTH) begin
                push_command(CMD_LOAD, IDX_W'(len), 5'd0, DUR_W'($urandom));
            end
            if (with_hold && sent == 0) hold_req = 1'b1;
            push_op(CMD_START);
            sent += len + 2;
            ops = $urandom_range(6, 20);
            repeat (ops) begin
                r = $urandom_range(99);
                if (r < 68) push_op(CMD_TICK);
                else if (r < 74) push_op(CMD_PAUSE);
                else if (r < 80) push_op(CMD_RESUME);
                else if (r < 84) push_op(CMD_STOP);
                else if (r < 88) push_op(CMD_START);
                else push_op(3'($urandom_range(0, 7)));
            end
            sent += ops;
        end
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !quiet_mode && $urandom_range(3) == 0) begin
                stall_left = ($urandom_range(9) == 0) ? $urandom_range(15, 50)
                                                      : $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_show got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.led     = o_shown_led;
            got.idx     = o_shown_index;
            got.dur     = o_shown_duration;
            got.fin     = o_finished;
            got.is_last = o_last;
            sb.check_show(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (psel && penable)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        int repeat_plan [6];
        repeat_plan = '{1, 3, 0, 255, 2, 1};
        sb            = new();
        quiet_mode    = 1'b0;
        hold_req      = 1'b0;
        stuck_cycles  = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_command     = CMD_LOAD;
        i_entry_index = '0;
        i_led_id      = '0;
        i_duration_ms = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = REPEAT_COUNT_ADDR;
        pwdata        = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Idle commands, an empty table and unused codes first.
        push_op(CMD_TICK);
        push_op(CMD_PAUSE);
        push_op(CMD_RESUME);
        push_op(CMD_START);
        push_op(CMD_STOP);
        push_op(CMD_RSVD6);
        push_op(CMD_RSVD7);
        // A three-step run with two zero holds; slot 15 takes the largest duration.
        push_command(CMD_LOAD, 4'd15, 5'd31, 16'hFFFF);
        push_command(CMD_LOAD, 4'd0, 5'd31, 16'd20);
        push_command(CMD_LOAD, 4'd1, 5'd1, 16'd0);
        push_command(CMD_LOAD, 4'd2, 5'd5, 16'd9);
        push_command(CMD_LOAD, 4'd3, 5'd0, 16'hFFFF);
        push_op(CMD_START);
        push_op(CMD_TICK);
        push_op(CMD_PAUSE);
        push_op(CMD_TICK);
        push_op(CMD_RESUME);
        push_op(CMD_TICK);
        push_op(CMD_TICK);
        push_op(CMD_START);
        push_op(CMD_START);
        push_op(CMD_STOP);
        push_op(CMD_TICK);

        foreach (repeat_plan[ph]) begin
            settle_idle();
            set_repeat_count(8'(repeat_plan[ph]));
            quiet_mode = (ph == 1);
            play_phase(PHASE_ITEMS, ph == 2);
        end
        quiet_mode = 1'b0;
        settle_idle();

        $display("Run covered %0d items and %0d results (%0d finished) over repeat counts",
                 sb.n_items, sb.n_results, sb.n_finished);
        $display("0 to 255, zero-hold runs, pause/resume, restarts and a long output stall.");
        if (sb.errors == 0 && sb.pending_shows.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
